/* design/string_literal_escape_decoder_defines.svh */
// Assertion macros for the string literal escape decoder.
// Included by the top level; no other dependencies.
`ifndef STRING_LITERAL_ESCAPE_DECODER_DEFINES_SVH
`define STRING_LITERAL_ESCAPE_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define SLESC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slesc check failed");
`define SLESC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slesc check failed");
`else
`define SLESC_ASSERT_IMP(label, clk, rst, ante, cons)
`define SLESC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/slesc_pkg.sv */
// Shared types and constants for the string literal escape decoder.
// No dependencies.
`timescale 1ns / 1ps

package slesc_pkg;

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_NORMAL = 5'b00010,
    MODE_ESC    = 5'b00100,
    MODE_OCT    = 5'b01000,
    MODE_HEX    = 5'b10000
  } mode_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t r0;
    logic v1;
    res_t r1;
  } pair_t;

  typedef struct packed {
    logic  push;
    pair_t data;
  } qwr_t;

  typedef struct packed {
    logic  empty;
    pair_t data;
  } qrd_t;

  // Hex digit test and value: {valid, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'b0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    return r;
  endfunction

endpackage

/* design/slesc_front.sv */
// Front part: accepts source bytes, runs the escape state machine and
// builds up to two results per item. Depends on slesc_pkg.
`timescale 1ns / 1ps

module slesc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_start,
  input  logic              q_full,
  output slesc_pkg::qwr_t   q_wr
);

  slesc_pkg::mode_t mode, mode_next;
  logic [7:0]       value, value_next;
  logic             accept;
  logic             pre_v, pl_do, pl_v;
  slesc_pkg::res_t  pre_r, pl_r;
  logic [4:0]       hx;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hx       = slesc_pkg::hex_digit(in_byte);

  always_comb begin
    mode_next  = mode;
    value_next = value;
    pre_v      = 1'b0;
    pre_r      = '0;
    pl_do      = 1'b0;
    pl_v       = 1'b0;
    pl_r       = '0;
    if (in_start) begin
      mode_next  = slesc_pkg::MODE_NORMAL;
      value_next = '0;
    end else begin
      case (mode)
        slesc_pkg::MODE_NORMAL: begin
          pl_do = 1'b1;
        end
        slesc_pkg::MODE_ESC: begin
          mode_next = slesc_pkg::MODE_NORMAL;
          pre_r.has = 1'b1;
          case (in_byte)
            slesc_pkg::CH_BSLASH: begin
              pre_v = 1'b1; pre_r.data = slesc_pkg::CH_BSLASH;
            end
            slesc_pkg::CH_N: begin
              pre_v = 1'b1; pre_r.data = slesc_pkg::CH_LF;
            end
            slesc_pkg::CH_T: begin
              pre_v = 1'b1; pre_r.data = slesc_pkg::CH_TAB;
            end
            slesc_pkg::CH_V: begin
              pre_v = 1'b1; pre_r.data = slesc_pkg::CH_VT;
            end
            slesc_pkg::CH_R: begin
              pre_v = 1'b1; pre_r.data = slesc_pkg::CH_CR;
            end
            slesc_pkg::CH_SQUOTE: begin
              pre_v = 1'b1; pre_r.data = slesc_pkg::CH_SQUOTE;
            end
            slesc_pkg::CH_DQUOTE: begin
              pre_v = 1'b1; pre_r.data = slesc_pkg::CH_DQUOTE;
            end
            slesc_pkg::CH_QMARK: begin
              pre_v = 1'b1; pre_r.data = slesc_pkg::CH_QMARK;
            end
            slesc_pkg::CH_X: begin
              value_next = '0;
              mode_next  = slesc_pkg::MODE_HEX;
            end
            default: begin
              if (in_byte inside {[8'h30:8'h37]}) begin
                value_next = {5'b0, in_byte[2:0]};
                mode_next  = slesc_pkg::MODE_OCT;
              end else begin
                pre_v      = 1'b1;
                pre_r.data = slesc_pkg::CH_BSLASH;
                pl_do      = 1'b1;
              end
            end
          endcase
        end
        slesc_pkg::MODE_OCT: begin
          if (in_byte inside {[8'h30:8'h37]}) begin
            value_next = {value[4:0], in_byte[2:0]};
          end else begin
            pre_v      = (value != '0);
            pre_r      = '{data: value, has: 1'b1, last: 1'b0};
            value_next = '0;
            pl_do      = 1'b1;
          end
        end
        slesc_pkg::MODE_HEX: begin
          if (hx[4]) begin
            value_next = {value[3:0], hx[3:0]};
          end else begin
            pre_v      = (value != '0);
            pre_r      = '{data: value, has: 1'b1, last: 1'b0};
            value_next = '0;
            pl_do      = 1'b1;
          end
        end
        default: begin
          mode_next = slesc_pkg::MODE_IDLE;
        end
      endcase
      if (pl_do) begin
        if (in_byte == slesc_pkg::CH_NUL || in_byte == slesc_pkg::CH_DQUOTE) begin
          pl_v       = 1'b1;
          pl_r       = '{data: 8'h00, has: 1'b0, last: 1'b1};
          mode_next  = slesc_pkg::MODE_IDLE;
          value_next = '0;
        end else if (in_byte == slesc_pkg::CH_BSLASH) begin
          mode_next = slesc_pkg::MODE_ESC;
        end else begin
          pl_v      = 1'b1;
          pl_r      = '{data: in_byte, has: 1'b1, last: 1'b0};
          mode_next = slesc_pkg::MODE_NORMAL;
        end
      end
    end
  end

  always_comb begin
    q_wr.push = accept && (pre_v || pl_v);
    if (pre_v) begin
      q_wr.data = '{r0: pre_r, v1: pl_v, r1: pl_r};
    end else begin
      q_wr.data = '{r0: pl_r, v1: 1'b0, r1: pl_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= slesc_pkg::MODE_IDLE;
      value <= '0;
    end else if (accept) begin
      mode  <= mode_next;
      value <= value_next;
    end
  end

endmodule

/* design/slesc_fifo.sv */
// Short queue of result pairs between the front and back parts.
// Depends on slesc_pkg.
`timescale 1ns / 1ps

module slesc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  slesc_pkg::qwr_t wr,
  output logic            full,
  input  logic            pop,
  output slesc_pkg::qrd_t rd
);

  slesc_pkg::pair_t             mem [slesc_pkg::QDepth];
  logic [slesc_pkg::QAw-1:0]    wptr, rptr;
  logic [slesc_pkg::QCw-1:0]    count;
  logic                         do_pop;

  assign full     = (count == slesc_pkg::QCw'(slesc_pkg::QDepth));
  assign rd.empty = (count == '0);
  assign rd.data  = mem[rptr];
  assign do_pop   = pop && !rd.empty;

  always_ff @(posedge clk) begin
    if (wr.push && !full) begin
      mem[wptr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr.push && !full) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      case ({wr.push && !full, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/slesc_back.sv */
// Back part: takes result pairs from the queue and, while the receiver is
// ready, sends them out one result per cycle through an output register. Depends on slesc_pkg.
`timescale 1ns / 1ps

module slesc_back (
  input  logic             clk,
  input  logic             rst,
  input  slesc_pkg::qrd_t  q_rd,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output slesc_pkg::res_t  out_res
);

  logic            load;
  logic            pend_valid;
  slesc_pkg::res_t pend;

  assign load  = !out_valid || out_ready;
  assign q_pop = load && !pend_valid && !q_rd.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!q_rd.empty) begin
        out_valid  <= 1'b1;
        pend_valid <= q_rd.data.v1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_res <= pend;
      end else if (!q_rd.empty) begin
        out_res <= q_rd.data.r0;
        pend    <= q_rd.data.r1;
      end
    end
  end

endmodule

/* design/string_literal_escape_decoder.sv */
// String literal escape decoder, top level.
// Depends on slesc_pkg, slesc_front, slesc_fifo, slesc_back and the defines header.
//
// Source bytes enter on the s_axis channel, one item per byte; tuser marks
// the opening quote, which is dropped and opens a new literal. Decoded
// characters leave on the m_axis channel: tdata is the character, tuser is
// set when tdata carries one, and tlast marks the bare end result of a
// literal. One source byte gives zero, one or two results.
// The input takes one byte every cycle while the four-entry result queue
// has room. Each accepted byte's first result is written to the queue,
// then to the output register; the two results of one byte leave in turn.
// Output rate is one result per cycle while the receiver is ready, so
// bytes giving two results limit sustained input to the output port rate.
// Reset empties the queue and output register and returns the decoder to
// idle, waiting for an opening quote. When the receiver stalls, the output
// register holds, the queue fills, and s_axis_tready drops once it is full.
`timescale 1ns / 1ps
`include "string_literal_escape_decoder_defines.svh"

module string_literal_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
  input  logic       s_axis_tuser,   // [0] start_flag
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] has_byte
  output logic       m_axis_tlast
);

  slesc_pkg::qwr_t q_wr;
  slesc_pkg::qrd_t q_rd;
  slesc_pkg::res_t out_res;
  logic            q_full;
  logic            q_pop;

  slesc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_start (s_axis_tuser),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  slesc_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_wr),
    .full (q_full),
    .pop  (q_pop),
    .rd   (q_rd)
  );

  slesc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = out_res.data;
  assign m_axis_tuser = out_res.has;
  assign m_axis_tlast = out_res.last;

  `SLESC_ASSERT_IMP(a_no_zero_char, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata != 8'h00)
  `SLESC_ASSERT_IMP(a_end_bare, clk, rst, m_axis_tvalid && m_axis_tlast, !m_axis_tuser && m_axis_tdata == 8'h00)
  `SLESC_ASSERT_IMP(a_bare_is_end, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
  `SLESC_ASSERT_NXT(a_full_blocks, clk, rst, q_full && !q_pop, !s_axis_tready)

endmodule

/* verif/string_literal_escape_decoder_test.sv */
// Self-checking testbench for string_literal_escape_decoder: streams quoted literals
// with escapes and noise, predicts the decoded characters and compares every result.
// Depends on slesc_pkg and the string_literal_escape_decoder RTL.
`timescale 1ns / 1ps

module string_literal_escape_decoder_test;

  typedef struct {
    logic [7:0] code;
    logic       opens;
  } src_item_t;

  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       last;
  } char_res_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tuser = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  src_item_t src_bytes[$];
  char_res_t decoded_chars[$];

  slesc_pkg::mode_t dec_mode = slesc_pkg::MODE_IDLE;
  logic [7:0]       esc_val = 8'h00;

  int errors = 0;
  int bytes_taken = 0;
  int chars_checked = 0;
  int literals_closed = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int ready_style = 0;
  int style_left = 0;
  bit long_hold_req = 1'b0;
  src_item_t nxt;
  char_res_t want;

  string hex_chars = "0123456789abcdefABCDEF";

  string_literal_escape_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic push_char(input logic [7:0] data, input logic has, input logic last);
    char_res_t r;
    r.data = data;
    r.has  = has;
    r.last = last;
    decoded_chars.push_back(r);
    if (last) literals_closed++;
  endtask

  task automatic plain_char(input logic [7:0] b);
    if (b == slesc_pkg::CH_NUL || b == slesc_pkg::CH_DQUOTE) begin
      push_char(slesc_pkg::CH_NUL, 1'b0, 1'b1);
      dec_mode = slesc_pkg::MODE_IDLE;
      esc_val  = 8'h00;
    end else if (b == slesc_pkg::CH_BSLASH) begin
      dec_mode = slesc_pkg::MODE_ESC;
    end else begin
      push_char(b, 1'b1, 1'b0);
      dec_mode = slesc_pkg::MODE_NORMAL;
    end
  endtask

  task automatic flush_run(input logic [7:0] b);
    if (esc_val != 8'h00) push_char(esc_val, 1'b1, 1'b0);
    esc_val  = 8'h00;
    dec_mode = slesc_pkg::MODE_NORMAL;
    plain_char(b);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic opens);
    int dv;
    if (opens) begin
      dec_mode = slesc_pkg::MODE_NORMAL;
      esc_val  = 8'h00;
    end else begin
      case (dec_mode)
        slesc_pkg::MODE_NORMAL: plain_char(b);
        slesc_pkg::MODE_ESC: begin
          dec_mode = slesc_pkg::MODE_NORMAL;
          case (b)
            slesc_pkg::CH_BSLASH: push_char(slesc_pkg::CH_BSLASH, 1'b1, 1'b0);
            slesc_pkg::CH_N:      push_char(slesc_pkg::CH_LF, 1'b1, 1'b0);
            slesc_pkg::CH_T:      push_char(slesc_pkg::CH_TAB, 1'b1, 1'b0);
            slesc_pkg::CH_V:      push_char(slesc_pkg::CH_VT, 1'b1, 1'b0);
            slesc_pkg::CH_R:      push_char(slesc_pkg::CH_CR, 1'b1, 1'b0);
            slesc_pkg::CH_SQUOTE: push_char(slesc_pkg::CH_SQUOTE, 1'b1, 1'b0);
            slesc_pkg::CH_DQUOTE: push_char(slesc_pkg::CH_DQUOTE, 1'b1, 1'b0);
            slesc_pkg::CH_QMARK:  push_char(slesc_pkg::CH_QMARK, 1'b1, 1'b0);
            slesc_pkg::CH_X: begin
              esc_val  = 8'h00;
              dec_mode = slesc_pkg::MODE_HEX;
            end
            default: begin
              if (b >= "0" && b <= "7") begin
                esc_val  = 8'(b - "0");
                dec_mode = slesc_pkg::MODE_OCT;
              end else begin
                push_char(slesc_pkg::CH_BSLASH, 1'b1, 1'b0);
                plain_char(b);
              end
            end
          endcase
        end
        slesc_pkg::MODE_OCT: begin
          if (b >= "0" && b <= "7") esc_val = 8'((esc_val << 3) + (b - "0"));
          else flush_run(b);
        end
        slesc_pkg::MODE_HEX: begin
          if (b >= "0" && b <= "9") dv = b - "0";
          else if (b >= "a" && b <= "f") dv = b - "a" + 10;
          else if (b >= "A" && b <= "F") dv = b - "A" + 10;
          else dv = -1;
          if (dv >= 0) esc_val = 8'((esc_val << 4) + dv);
          else flush_run(b);
        end
        default: dec_mode = slesc_pkg::MODE_IDLE;
      endcase
    end
  endtask

  // Sender: bursts of random length with random gaps, no gaps during a long hold.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tuser  <= 1'b0;
      dec_mode = slesc_pkg::MODE_IDLE;
      esc_val  = 8'h00;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tuser);
        bytes_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 && hold_left == 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (src_bytes.size() > 0) begin
          nxt = src_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.code;
          s_axis_tuser  <= nxt.opens;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switch at random between stall styles; take long holds on request.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left   = 0;
      style_left  = 0;
    end else begin
      if (long_hold_req && hold_left == 0) begin
        hold_left     = 80;
        long_hold_req = 1'b0;
      end
      if (style_left == 0) begin
        ready_style = $urandom_range(0, 3);
        style_left  = $urandom_range(16, 96);
      end else begin
        style_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (ready_style)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= (style_left % 3 != 0);
          default: m_axis_tready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (decoded_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected result data %h has %b last %b", $time,
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = decoded_chars.pop_front();
        chars_checked++;
        if (m_axis_tdata !== want.data) begin
          errors++;
          $display("%0t: out_byte expected %h actual %h", $time, want.data, m_axis_tdata);
        end
        if (m_axis_tuser !== want.has) begin
          errors++;
          $display("%0t: has_byte expected %b actual %b", $time, want.has, m_axis_tuser);
        end
        if (m_axis_tlast !== want.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, want.last, m_axis_tlast);
        end
      end
    end
  end

  task automatic add_src(input logic [7:0] code, input logic opens);
    src_item_t it;
    it.code  = code;
    it.opens = opens;
    src_bytes.push_back(it);
  endtask

  task automatic add_plain_text();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == slesc_pkg::CH_BSLASH || b == slesc_pkg::CH_DQUOTE);
    add_src(b, 1'b0);
  endtask

  task automatic add_random_literal();
    int tokens;
    int n;
    logic [7:0] b;
    logic [7:0] simple_esc[8];
    simple_esc = '{slesc_pkg::CH_BSLASH, slesc_pkg::CH_N, slesc_pkg::CH_T, slesc_pkg::CH_V,
                   slesc_pkg::CH_R, slesc_pkg::CH_SQUOTE, slesc_pkg::CH_DQUOTE,
                   slesc_pkg::CH_QMARK};
    if ($urandom_range(0, 9) == 0) begin
      // noise: loose bytes, stray openings, raw terminators
      n = $urandom_range(1, 8);
      repeat (n) add_src(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end else begin
      add_src(slesc_pkg::CH_DQUOTE, 1'b1);
      tokens = $urandom_range(0, 10);
      repeat (tokens) begin
        case ($urandom_range(0, 5))
          0, 1: add_plain_text();
          2: begin
            add_src(slesc_pkg::CH_BSLASH, 1'b0);
            add_src(simple_esc[$urandom_range(0, 7)], 1'b0);
          end
          3: begin
            add_src(slesc_pkg::CH_BSLASH, 1'b0);
            n = $urandom_range(1, 4);
            repeat (n) add_src(8'("0" + $urandom_range(0, 7)), 1'b0);
          end
          4: begin
            add_src(slesc_pkg::CH_BSLASH, 1'b0);
            add_src(slesc_pkg::CH_X, 1'b0);
            n = $urandom_range(0, 3);
            repeat (n) add_src(hex_chars[$urandom_range(0, 21)], 1'b0);
          end
          default: begin
            do b = 8'($urandom_range(1, 255));
            while (b inside {slesc_pkg::CH_BSLASH, slesc_pkg::CH_N, slesc_pkg::CH_T,
                             slesc_pkg::CH_V, slesc_pkg::CH_R, slesc_pkg::CH_SQUOTE,
                             slesc_pkg::CH_DQUOTE, slesc_pkg::CH_QMARK, slesc_pkg::CH_X} ||
                   (b >= "0" && b <= "7"));
            add_src(slesc_pkg::CH_BSLASH, 1'b0);
            add_src(b, 1'b0);
          end
        endcase
      end
      case ($urandom_range(0, 9))
        0:       ;
        1, 2:    add_src(slesc_pkg::CH_NUL, 1'b0);
        default: add_src(slesc_pkg::CH_DQUOTE, 1'b0);
      endcase
    end
  endtask

  task automatic wait_drained();
    while (src_bytes.size() > 0 || s_axis_tvalid || decoded_chars.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    add_src("A", 1'b0);
    add_src(slesc_pkg::CH_DQUOTE, 1'b1);
    add_src(8'hFF, 1'b0);
    add_src(slesc_pkg::CH_BSLASH, 1'b0);
    add_src(slesc_pkg::CH_N, 1'b0);
    add_src(slesc_pkg::CH_BSLASH, 1'b0);
    add_src("q", 1'b0);
    add_src(slesc_pkg::CH_BSLASH, 1'b0);
    add_src("7", 1'b0);
    add_src("7", 1'b0);
    add_src("7", 1'b0);
    add_src(8'h01, 1'b0);
    add_src(slesc_pkg::CH_BSLASH, 1'b0);
    add_src(slesc_pkg::CH_X, 1'b0);
    add_src("a", 1'b0);
    add_src("F", 1'b0);
    add_src(slesc_pkg::CH_DQUOTE, 1'b0);
    add_src(slesc_pkg::CH_DQUOTE, 1'b1);
    add_src(slesc_pkg::CH_BSLASH, 1'b0);
    add_src(slesc_pkg::CH_X, 1'b0);
    add_src("g", 1'b0);
    add_src(slesc_pkg::CH_BSLASH, 1'b0);
    add_src("0", 1'b0);
    add_src(slesc_pkg::CH_DQUOTE, 1'b1);
    add_src(slesc_pkg::CH_BSLASH, 1'b0);
    add_src(slesc_pkg::CH_NUL, 1'b0);
    wait_drained();

    while (src_bytes.size() < 200) add_random_literal();
    @(negedge clk);
    long_hold_req = 1'b1;
    wait_drained();

    while (src_bytes.size() < 230) add_random_literal();
    wait_drained();

    repeat (20) @(posedge clk);
    $display("Streamed %0d source bytes; checked %0d decoded results over %0d closed literals.",
             bytes_taken, chars_checked, literals_closed);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
